// ===== rtl/set_associative_lru_cache_model_unit_defines.svh =====
// Assertion helpers shared by the cache RTL.
// Every property is clocked on clk and is off while rst_n is low.
`ifndef SET_ASSOCIATIVE_LRU_CACHE_MODEL_UNIT_DEFINES_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_MODEL_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SALC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache assertion failed");

// Next-cycle implication.
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache assertion failed");

`endif

// ===== rtl/salc_pkg.sv =====
package salc_pkg;

  localparam int SET_COUNT_LOG = 6;
  localparam int SET_COUNT     = 1 << SET_COUNT_LOG;
  localparam int WAY_COUNT     = 4;
  localparam int WAY_W         = $clog2(WAY_COUNT);
  localparam int ADDR_W        = 32;
  localparam int TAG_W         = ADDR_W - SET_COUNT_LOG;
  localparam int CNT_W         = 32;
  localparam int BSL_W         = 4;
  localparam int SH_W          = 6;
  localparam int OUT_WAY_W     = 2;
  localparam int PADDR_W       = 4;
  localparam int DATA_W        = 32;

  // page-number hash
  localparam int PAGE_BITS     = 12;
  localparam int MEM_BITS      = 30;
  localparam int HASH_SHIFT_HI = 16;
  localparam int HASH_SHIFT_LO = 2;
  localparam logic [ADDR_W-1:0] PPN_MASK =
    ((32'hFFFF_FFFF << (ADDR_W - MEM_BITS)) >> (ADDR_W - MEM_BITS + PAGE_BITS)) << PAGE_BITS;
  localparam logic [ADDR_W-1:0] PAGE_MASK = (32'd1 << PAGE_BITS) - 32'd1;

  localparam logic [BSL_W-1:0] BSL_RESET = 4'd6;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    REG_BLOCK_SIZE_LOG = 2'd0,
    REG_PHYSICAL_INDEX = 2'd1,
    REG_PHYSICAL_TAG   = 2'd2
  } cfg_reg_t;

  typedef logic [SET_COUNT_LOG-1:0]            set_t;
  typedef logic [TAG_W-1:0]                    tag_t;
  typedef logic [WAY_W-1:0]                    way_t;
  typedef logic [CNT_W-1:0]                    cnt_t;
  typedef logic [BSL_W-1:0]                    bsl_t;
  typedef logic [WAY_COUNT-1:0]                vld_row_t;
  typedef logic [WAY_COUNT-1:0][TAG_W-1:0]     tag_row_t;
  typedef logic [WAY_COUNT-1:0][WAY_W-1:0]     lru_row_t;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way_used;
    cnt_t                 read_count;
    cnt_t                 read_hit_count;
    cnt_t                 write_count;
    cnt_t                 write_hit_count;
  } out_item_t;

  typedef struct packed {
    logic hit;
    way_t way;
  } way_dec_t;

  // order after reset: position 0 (LRU) holds way 0
  function automatic lru_row_t lru_reset_row();
    lru_row_t row;
    for (int i = 0; i < WAY_COUNT; i++) begin
      row[i] = WAY_W'(i);
    end
    return row;
  endfunction

  function automatic cnt_t sat_inc(cnt_t c);
    return (c == '1) ? c : c + cnt_t'(1);
  endfunction

endpackage

// ===== rtl/salc_addr_map.sv =====
module salc_addr_map (
  input  logic [salc_pkg::ADDR_W-1:0] address,
  input  salc_pkg::bsl_t              block_size_log,
  input  logic                        physical_index,
  input  logic                        physical_tag,
  output salc_pkg::set_t              set_idx,
  output salc_pkg::tag_t              tag
);

  logic [salc_pkg::ADDR_W-1:0] va;
  logic [salc_pkg::ADDR_W-1:0] vpn;
  logic [salc_pkg::ADDR_W-1:0] hash;
  logic [salc_pkg::ADDR_W-1:0] pa;
  logic [salc_pkg::ADDR_W-1:0] ia;
  logic [salc_pkg::ADDR_W-1:0] ta;
  logic [salc_pkg::SH_W-1:0]   tag_sh;

  always_comb begin
    va   = {address[salc_pkg::ADDR_W-1:2], 2'b00};
    vpn  = va >> salc_pkg::PAGE_BITS;
    hash = (~vpn ^ (vpn << salc_pkg::HASH_SHIFT_HI))
         + (vpn & (vpn << salc_pkg::HASH_SHIFT_HI))
         + (~vpn | (vpn << salc_pkg::HASH_SHIFT_LO));
    pa   = ((hash & salc_pkg::PPN_MASK) << salc_pkg::PAGE_BITS) + (va & salc_pkg::PAGE_MASK);
    ia   = physical_index ? pa : va;
    ta   = physical_tag ? pa : va;
    tag_sh  = salc_pkg::SH_W'(block_size_log) + salc_pkg::SH_W'(salc_pkg::SET_COUNT_LOG);
    set_idx = salc_pkg::SET_COUNT_LOG'(ia >> block_size_log);
    tag     = salc_pkg::TAG_W'(ta >> tag_sh);
  end

endmodule

// ===== rtl/salc_way_sel.sv =====
module salc_way_sel (
  input  salc_pkg::tag_t     tag,
  input  salc_pkg::tag_row_t tag_row,
  input  salc_pkg::vld_row_t vld_row,
  input  salc_pkg::lru_row_t lru_row,
  output salc_pkg::way_dec_t dec,
  output salc_pkg::lru_row_t lru_nxt
);

  logic           hit;
  salc_pkg::way_t hit_way;
  salc_pkg::way_t free_way;
  salc_pkg::way_t way;
  salc_pkg::way_t pos;

  // lowest matching way wins; fill goes to lowest invalid way, else LRU
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free_way = lru_row[0];
    for (int w = salc_pkg::WAY_COUNT - 1; w >= 0; w--) begin
      if (vld_row[w] && (tag_row[w] == tag)) begin
        hit     = 1'b1;
        hit_way = salc_pkg::WAY_W'(w);
      end
      if (!vld_row[w]) begin
        free_way = salc_pkg::WAY_W'(w);
      end
    end
    way     = hit ? hit_way : free_way;
    dec.hit = hit;
    dec.way = way;
  end

  // move the touched way to the MRU end
  always_comb begin
    pos = '0;
    for (int i = 0; i < salc_pkg::WAY_COUNT; i++) begin
      if (lru_row[i] == way) begin
        pos = salc_pkg::WAY_W'(i);
      end
    end
    for (int i = 0; i < salc_pkg::WAY_COUNT - 1; i++) begin
      lru_nxt[i] = (salc_pkg::WAY_W'(i) < pos) ? lru_row[i] : lru_row[i+1];
    end
    lru_nxt[salc_pkg::WAY_COUNT-1] = way;
  end

endmodule

// ===== rtl/set_associative_lru_cache_model_unit.sv =====
// Tag store model of a 4-way set-associative cache with LRU replacement.
// Input channel (in_valid/in_stall/in_data): one access per transaction,
// opcode (read/write) plus a 32-bit virtual byte address.
// Result channel (out_valid/out_stall/out_data): one result per access with
// hit flag, way used and the four saturating request/hit counters.
// APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready): block size log2
// at 0x0, physical index select at 0x4, physical tag select at 0x8.
// Throughput: one access per cycle while out_stall is low. The set read of the
// tag and LRU memories is registered at the input transaction edge; compare,
// victim choice and update in the compare stage write the result register.
// A fill made in the update cycle is forwarded to the access read behind it.
// in_stall is high while the compare stage holds an access and a stalled
// result waits in the output register; a stalled result is held there.
// Reset: synchronous, resets valid bits, counters and configuration; no
// clearing pass is needed, a set with no valid way reads LRU order 0,1,2,3.
`include "set_associative_lru_cache_model_unit_defines.svh"

module set_associative_lru_cache_model_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  salc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output salc_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [salc_pkg::PADDR_W-1:0]   paddr,
  input  logic [salc_pkg::DATA_W-1:0]    pwdata,
  output logic [salc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  // configuration
  salc_pkg::bsl_t     bsl_r;
  logic               pidx_r;
  logic               ptag_r;
  logic               cfg_wr;
  salc_pkg::cfg_reg_t reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = salc_pkg::cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsl_r  <= salc_pkg::BSL_RESET;
      pidx_r <= 1'b0;
      ptag_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        salc_pkg::REG_BLOCK_SIZE_LOG: bsl_r  <= pwdata[salc_pkg::BSL_W-1:0];
        salc_pkg::REG_PHYSICAL_INDEX: pidx_r <= pwdata[0];
        salc_pkg::REG_PHYSICAL_TAG:   ptag_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      salc_pkg::REG_BLOCK_SIZE_LOG: prdata = salc_pkg::DATA_W'(bsl_r);
      salc_pkg::REG_PHYSICAL_INDEX: prdata = salc_pkg::DATA_W'(pidx_r);
      salc_pkg::REG_PHYSICAL_TAG:   prdata = salc_pkg::DATA_W'(ptag_r);
      default:                      prdata = '0;
    endcase
  end

  // address slicing at the port, feeds the memory read address
  salc_pkg::set_t in_set;
  salc_pkg::tag_t in_tag;

  salc_addr_map u_addr_map (
    .address        (in_data.address),
    .block_size_log (bsl_r),
    .physical_index (pidx_r),
    .physical_tag   (ptag_r),
    .set_idx        (in_set),
    .tag            (in_tag)
  );

  // handshake
  logic a_vld_r;
  logic out_vld_r;
  logic out_free;
  logic a_adv;
  logic in_acc;

  assign out_free  = !out_vld_r || !out_stall;
  assign a_adv     = a_vld_r && out_free;
  assign in_stall  = a_vld_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_vld_r;

  // compare stage
  logic               a_op_r;
  salc_pkg::set_t     a_set_r;
  salc_pkg::tag_t     a_tag_r;
  salc_pkg::tag_row_t tag_rd_r;
  salc_pkg::lru_row_t lru_rd_r;

  // forward of the row written at the edge that loaded the compare stage
  logic               byp_vld_r;
  salc_pkg::set_t     byp_set_r;
  logic               byp_fill_r;
  salc_pkg::tag_row_t byp_tag_row_r;
  salc_pkg::lru_row_t byp_lru_r;

  logic [salc_pkg::SET_COUNT-1:0][salc_pkg::WAY_COUNT-1:0] vld_r;

  salc_pkg::tag_row_t tag_mem [salc_pkg::SET_COUNT];
  salc_pkg::lru_row_t lru_mem [salc_pkg::SET_COUNT];

  logic               byp_hit;
  salc_pkg::tag_row_t tag_row;
  salc_pkg::vld_row_t vld_row;
  salc_pkg::lru_row_t lru_row;
  salc_pkg::tag_row_t tag_wr_row;
  salc_pkg::lru_row_t lru_nxt;
  salc_pkg::way_dec_t dec;

  always_comb begin
    byp_hit = byp_vld_r && (byp_set_r == a_set_r);
    vld_row = vld_r[a_set_r];
    tag_row = (byp_hit && byp_fill_r) ? byp_tag_row_r : tag_rd_r;
    if (byp_hit) begin
      lru_row = byp_lru_r;
    end else if (|vld_row) begin
      lru_row = lru_rd_r;
    end else begin
      lru_row = salc_pkg::lru_reset_row();
    end
  end

  salc_way_sel u_way_sel (
    .tag     (a_tag_r),
    .tag_row (tag_row),
    .vld_row (vld_row),
    .lru_row (lru_row),
    .dec     (dec),
    .lru_nxt (lru_nxt)
  );

  always_comb begin
    tag_wr_row          = tag_row;
    tag_wr_row[dec.way] = a_tag_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_rd_r <= tag_mem[in_set];
      lru_rd_r <= lru_mem[in_set];
    end
    if (a_adv) begin
      lru_mem[a_set_r] <= lru_nxt;
      if (!dec.hit) begin
        tag_mem[a_set_r] <= tag_wr_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_op_r        <= in_data.opcode;
      a_set_r       <= in_set;
      a_tag_r       <= in_tag;
      byp_set_r     <= a_set_r;
      byp_fill_r    <= !dec.hit;
      byp_tag_row_r <= tag_wr_row;
      byp_lru_r     <= lru_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      byp_vld_r <= 1'b0;
      vld_r     <= '0;
    end else begin
      if (in_acc) begin
        a_vld_r   <= 1'b1;
        byp_vld_r <= a_adv;
      end else if (a_adv) begin
        a_vld_r <= 1'b0;
      end
      if (a_adv) begin
        vld_r[a_set_r][dec.way] <= 1'b1;
      end
    end
  end

  // counters and result register
  salc_pkg::cnt_t rd_cnt_r;
  salc_pkg::cnt_t rd_hit_cnt_r;
  salc_pkg::cnt_t wr_cnt_r;
  salc_pkg::cnt_t wr_hit_cnt_r;
  salc_pkg::cnt_t rd_cnt_nxt;
  salc_pkg::cnt_t rd_hit_cnt_nxt;
  salc_pkg::cnt_t wr_cnt_nxt;
  salc_pkg::cnt_t wr_hit_cnt_nxt;
  salc_pkg::out_item_t out_data_r;
  logic is_wr;

  always_comb begin
    is_wr          = (a_op_r == salc_pkg::OP_WRITE);
    rd_cnt_nxt     = rd_cnt_r;
    rd_hit_cnt_nxt = rd_hit_cnt_r;
    wr_cnt_nxt     = wr_cnt_r;
    wr_hit_cnt_nxt = wr_hit_cnt_r;
    if (is_wr) begin
      wr_cnt_nxt = salc_pkg::sat_inc(wr_cnt_r);
      if (dec.hit) begin
        wr_hit_cnt_nxt = salc_pkg::sat_inc(wr_hit_cnt_r);
      end
    end else begin
      rd_cnt_nxt = salc_pkg::sat_inc(rd_cnt_r);
      if (dec.hit) begin
        rd_hit_cnt_nxt = salc_pkg::sat_inc(rd_hit_cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r    <= 1'b0;
      rd_cnt_r     <= '0;
      rd_hit_cnt_r <= '0;
      wr_cnt_r     <= '0;
      wr_hit_cnt_r <= '0;
    end else begin
      if (a_adv) begin
        out_vld_r    <= 1'b1;
        rd_cnt_r     <= rd_cnt_nxt;
        rd_hit_cnt_r <= rd_hit_cnt_nxt;
        wr_cnt_r     <= wr_cnt_nxt;
        wr_hit_cnt_r <= wr_hit_cnt_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_data_r.hit             <= dec.hit;
      out_data_r.way_used        <= salc_pkg::OUT_WAY_W'(dec.way);
      out_data_r.read_count      <= rd_cnt_nxt;
      out_data_r.read_hit_count  <= rd_hit_cnt_nxt;
      out_data_r.write_count     <= wr_cnt_nxt;
      out_data_r.write_hit_count <= wr_hit_cnt_nxt;
    end
  end

  assign out_data = out_data_r;

  `SALC_ASSERT_IMPLIES(a_hit_on_valid_way, a_adv && dec.hit, vld_row[dec.way])
  `SALC_ASSERT_IMPLIES(a_fill_prefers_free, a_adv && !dec.hit && !(&vld_row), !vld_row[dec.way])
  `SALC_ASSERT_NEXT(a_adv_loads_result, a_adv, out_vld_r && out_data_r.hit == $past(dec.hit))
  `SALC_ASSERT_IMPLIES(a_hits_bounded, 1'b1, rd_hit_cnt_r <= rd_cnt_r && wr_hit_cnt_r <= wr_cnt_r)

endmodule
